// ===== sv/sac_pkg.sv =====
// Package: shared types, codes and constants of the servo ack frame checker.
package sac_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;

  // Result kinds
  localparam logic OUT_PAYLOAD = 1'b0;
  localparam logic OUT_STATUS  = 1'b1;

  // Frame status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_HDR_TIMEOUT = 4'd1;
  localparam logic [3:0] ST_BYTE1       = 4'd2;
  localparam logic [3:0] ST_BYTE2       = 4'd3;
  localparam logic [3:0] ST_ID          = 4'd4;
  localparam logic [3:0] ST_CMD         = 4'd5;
  localparam logic [3:0] ST_SIZE        = 4'd6;
  localparam logic [3:0] ST_D1_TIMEOUT  = 4'd7;
  localparam logic [3:0] ST_D2_TIMEOUT  = 4'd8;
  localparam logic [3:0] ST_CHK1        = 4'd9;
  localparam logic [3:0] ST_CHK2        = 4'd10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_CMD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TO     = 3'd5;
  localparam int CFG_DATA_W = 16;

  // Frame constants
  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [7:0]  ACK_FLAG      = 8'h40;
  localparam logic [7:0]  CHK_MASK      = 8'hFE;
  localparam logic [7:0]  HDR_BYTES     = 8'd7;
  localparam int          HDR_LEN       = 7;
  localparam logic [15:0] SHORT_TO_RST  = 16'd20;
  localparam logic [15:0] LONG_TO_RST   = 16'd1000;

  // Result queue depth
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [7:0]  request_cmd;
    logic [7:0]  first_len;
    logic [7:0]  second_len;
    logic [15:0] short_to;
    logic [15:0] long_to;
  } cfg_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] payload_byte;
    logic       payload_part;
    logic [7:0] payload_index;
    logic [3:0] status;
    logic       last;
  } res_t;

  function automatic res_t mk_status(input logic [3:0] st);
    res_t r;
    r = '0;
    r.out_kind = OUT_STATUS;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_payload(input logic [7:0] b, input logic part,
                                      input logic [7:0] idx);
    res_t r;
    r = '0;
    r.out_kind      = OUT_PAYLOAD;
    r.payload_byte  = b;
    r.payload_part  = part;
    r.payload_index = idx;
    r.last          = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/sac_in_if.sv =====
// Interface: input item channel (function code and received byte).
interface sac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

// ===== sv/sac_out_if.sv =====
// Interface: result channel (payload bytes and frame status).
interface sac_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] payload_byte;
  logic       payload_part;
  logic [7:0] payload_index;
  logic [3:0] status;
  logic       last;

  modport source (output valid, out_kind, payload_byte, payload_part, payload_index,
                  status, last, input ready);
  modport sink (input valid, out_kind, payload_byte, payload_part, payload_index,
                status, last, output ready);
endinterface

// ===== sv/sac_core.sv =====
// Frame checker core: phase tracking, header checks, checksum and timeouts.
module sac_core
  import sac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [1:0] func,
  input  logic [7:0] rx_byte,
  output logic       push0,
  output logic       push1,
  output res_t       res0,
  output res_t       res1
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA1,
    PH_DATA2
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  hdr [HDR_LEN];
  logic        hdr_we;

  logic [7:0]  ack_cmd, frame_size, hdr_xor, data_xor, part_len, count_inc;
  logic [15:0] limit, tick_inc;

  function automatic logic [3:0] chk_status(input logic [7:0] h5, input logic [7:0] h6,
                                            input logic [7:0] x);
    logic [3:0] st;
    st = ST_OK;
    if (h5 != (x & CHK_MASK)) st = ST_CHK1;
    else if (h6 != (~x & CHK_MASK)) st = ST_CHK2;
    return st;
  endfunction

  assign ack_cmd    = cfg.request_cmd | ACK_FLAG;
  assign frame_size = HDR_BYTES + cfg.first_len + cfg.second_len;
  assign hdr_xor    = frame_size ^ cfg.servo_id ^ ack_cmd;
  assign data_xor   = running_xor ^ rx_byte;
  assign part_len   = (phase == PH_DATA2) ? cfg.second_len : cfg.first_len;
  assign count_inc  = (byte_count != 8'hFF) ? byte_count + 8'd1 : byte_count;
  assign tick_inc   = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;

  always_comb begin
    if (phase == PH_DATA2) limit = cfg.long_to;
    else limit = cfg.short_to;
    if (limit == '0) limit = 16'd1;
  end

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    tick_count_next  = tick_count;
    hdr_we           = 1'b0;
    push0            = 1'b0;
    push1            = 1'b0;
    res0             = '0;
    res1             = '0;
    if (accept) begin
      case (func)
        FUNC_START: begin
          phase_next       = PH_HEADER;
          byte_count_next  = '0;
          tick_count_next  = '0;
          running_xor_next = '0;
        end
        FUNC_BYTE: begin
          case (phase)
            PH_HEADER: begin
              hdr_we          = 1'b1;
              byte_count_next = byte_count + 8'd1;
              if (byte_count == HDR_BYTES - 8'd1) begin
                push0      = 1'b1;
                phase_next = PH_IDLE;
                if (hdr[0] != SYNC_BYTE) res0 = mk_status(ST_BYTE1);
                else if (hdr[1] != SYNC_BYTE) res0 = mk_status(ST_BYTE2);
                else if (hdr[3] != cfg.servo_id) res0 = mk_status(ST_ID);
                else if (hdr[4] != ack_cmd) res0 = mk_status(ST_CMD);
                else if (hdr[2] != frame_size) res0 = mk_status(ST_SIZE);
                else begin
                  running_xor_next = hdr_xor;
                  if (cfg.first_len != '0) begin
                    push0           = 1'b0;
                    phase_next      = PH_DATA1;
                    byte_count_next = '0;
                    tick_count_next = '0;
                  end else if (cfg.second_len != '0) begin
                    push0           = 1'b0;
                    phase_next      = PH_DATA2;
                    byte_count_next = '0;
                    tick_count_next = '0;
                  end else begin
                    // byte 6 is the one arriving now
                    res0 = mk_status(chk_status(hdr[5], rx_byte, hdr_xor));
                  end
                end
              end
            end
            PH_DATA1, PH_DATA2: begin
              push0            = 1'b1;
              res0             = mk_payload(rx_byte, phase == PH_DATA2, byte_count);
              running_xor_next = data_xor;
              byte_count_next  = count_inc;
              if (count_inc >= part_len) begin
                if (phase == PH_DATA1 && cfg.second_len != '0) begin
                  phase_next      = PH_DATA2;
                  byte_count_next = '0;
                  tick_count_next = '0;
                end else begin
                  res0.last  = 1'b0;
                  push1      = 1'b1;
                  res1       = mk_status(chk_status(hdr[5], hdr[6], data_xor));
                  phase_next = PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
        default: begin
          // millisecond tick
          if (phase != PH_IDLE) begin
            tick_count_next = tick_inc;
            if (tick_inc >= limit) begin
              push0      = 1'b1;
              phase_next = PH_IDLE;
              case (phase)
                PH_HEADER: res0 = mk_status(ST_HDR_TIMEOUT);
                PH_DATA1:  res0 = mk_status(ST_D1_TIMEOUT);
                default:   res0 = mk_status(ST_D2_TIMEOUT);
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_count  <= '0;
      running_xor <= '0;
      tick_count  <= '0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
      tick_count  <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr[byte_count[2:0]] <= rx_byte;
  end

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0 && !res0.last && res0.out_kind == OUT_PAYLOAD
              && res1.out_kind == OUT_STATUS)
    else $error("second result not a status after a payload");

  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (push0 && res0.out_kind == OUT_STATUS) || push1 |=> phase == PH_IDLE)
    else $error("status given but frame still active");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE && func != FUNC_START |-> !push0)
    else $error("result produced while idle");
`endif

endmodule

// ===== sv/sac_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one per transfer.
module sac_out_fifo
  import sac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push0,
  input  logic push1,
  input  res_t res0,
  input  res_t res1,
  output logic room,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = PTR_W + 1;

  res_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  logic [CNT_W-1:0] push_n;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_res   = mem[rd_ptr];
  assign room      = count <= CNT_W'(QDEPTH - 2);
  assign push_n    = CNT_W'(push0) + CNT_W'(push1);
  assign count_next = count + push_n - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PTR_W-1:0];
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= res0;
    if (push1) mem[wr_ptr + PTR_W'(1)] <= res1;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push0 |-> count - CNT_W'(pop) <= CNT_W'(QDEPTH) - push_n)
    else $error("result queue overflow");
`endif

endmodule

// ===== sv/servo_ack_frame_checker.sv =====
// An accepted item's results are written into the registered result queue,
// which presents them on the result channel. One item per cycle while the
// four-entry result queue has two or more free entries; otherwise input waits.
// Reset (rst, synchronous, active high): idle phase, empty queue,
// registers back to id 0, command 0, lengths 0, timeouts 20 and 1000 ms.
module servo_ack_frame_checker
  import sac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sac_in_if.sink               in_ch,
  sac_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic accept;
  logic room;
  logic push0, push1;
  res_t res0, res1;
  res_t out_res;

  // Configuration registers, written at any edge with cfg_we high.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.servo_id    <= '0;
      cfg.request_cmd <= '0;
      cfg.first_len   <= '0;
      cfg.second_len  <= '0;
      cfg.short_to    <= SHORT_TO_RST;
      cfg.long_to     <= LONG_TO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERVO_ID:    cfg.servo_id    <= cfg_data[7:0];
        CFG_REQUEST_CMD: cfg.request_cmd <= cfg_data[7:0];
        CFG_FIRST_LEN:   cfg.first_len   <= cfg_data[7:0];
        CFG_SECOND_LEN:  cfg.second_len  <= cfg_data[7:0];
        CFG_SHORT_TO:    cfg.short_to    <= cfg_data;
        CFG_LONG_TO:     cfg.long_to     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input is taken whenever the queue can absorb the worst case of two results,
  // so a waiting result never blocks the input side by itself.
  assign in_ch.ready = room;
  assign accept      = in_ch.valid && in_ch.ready;

  sac_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .func    (in_ch.func),
    .rx_byte (in_ch.rx_byte),
    .push0   (push0),
    .push1   (push1),
    .res0    (res0),
    .res1    (res1)
  );

  sac_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // Result transfer fields straight from the queue head.
  assign out_ch.out_kind      = out_res.out_kind;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.payload_part  = out_res.payload_part;
  assign out_ch.payload_index = out_res.payload_index;
  assign out_ch.status        = out_res.status;
  assign out_ch.last          = out_res.last;

endmodule

// ===== tb/servo_ack_frame_checker_tb.sv =====
// Testbench: servo ack frame checker against a cycle-free frame tracker.
module servo_ack_frame_checker_tb
  import sac_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Tick codes: the block takes both of the upper codes as a millisecond tick
  localparam logic [1:0] FUNC_TICK     = 2'd2;
  localparam logic [1:0] FUNC_ALT_TICK = 2'd3;

  localparam int ITEM_TARGET   = 1950;  // frame transfers in the random part
  localparam int CALM_ITEMS    = 250;   // tail of the run with no idling at all
  localparam int LONG_HOLD     = 80;    // receiver hold-off that fills the result queue
  localparam int SETTLE_CYCLES = 8;     // a start or tick gives no result: let it land
  localparam int STALL_LIMIT   = 3000;  // cycles with no transfer on either channel
  localparam int MAX_PRINTED   = 40;    // mismatch lines shown; the rest only counted
  localparam int TIMEOUT_REACH = 40;    // longest tick run sent to force a timeout

  typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_DATA1, PH_DATA2} frame_phase_t;

  // Ways of spoiling a frame; the header ones map onto one header byte each
  typedef enum int {
    FAULT_NONE, FAULT_SYNC0, FAULT_SYNC1, FAULT_SIZE, FAULT_ID, FAULT_CMD,
    FAULT_CHK1, FAULT_CHK2, FAULT_HDR_TIMEOUT, FAULT_D1_TIMEOUT, FAULT_D2_TIMEOUT,
    FAULT_TRUNCATE
  } frame_fault_t;

  // Tracks the frame the block is parsing and queues the results it owes.
  class ack_frame_tracker;
    logic [7:0]   servo_id, request_cmd, first_len, second_len;
    logic [15:0]  short_to, long_to;
    frame_phase_t phase;
    logic [7:0]   byte_count;
    logic [7:0]   hdr_bytes [HDR_LEN];
    logic [7:0]   frame_xor;
    logic [15:0]  tick_count;
    res_t         due_results [$];
    int           mismatch_count;
    int           results_seen;

    function new();
      restore();
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    function void restore();
      servo_id    = '0;
      request_cmd = '0;
      first_len   = '0;
      second_len  = '0;
      short_to    = SHORT_TO_RST;
      long_to     = LONG_TO_RST;
      phase       = PH_IDLE;
      byte_count  = '0;
      frame_xor   = '0;
      tick_count  = '0;
      due_results.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SERVO_ID:    servo_id    = data[7:0];
        CFG_REQUEST_CMD: request_cmd = data[7:0];
        CFG_FIRST_LEN:   first_len   = data[7:0];
        CFG_SECOND_LEN:  second_len  = data[7:0];
        CFG_SHORT_TO:    short_to    = data;
        CFG_LONG_TO:     long_to     = data;
        default: ;
      endcase
    endfunction

    // size field wraps at 256
    function logic [7:0] frame_size();
      return HDR_BYTES + first_len + second_len;
    endfunction

    function void finish_frame(logic [3:0] st);
      res_t r;
      r          = '0;
      r.out_kind = OUT_STATUS;
      r.status   = st;
      r.last     = 1'b1;
      due_results.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void enter(frame_phase_t p);
      phase      = p;
      byte_count = '0;
      tick_count = '0;
    endfunction

    // next data part, or the checksum verdict when no part is left
    function void move_on(bit from_header);
      if (from_header && first_len != 0) begin
        enter(PH_DATA1);
        return;
      end
      if (phase != PH_DATA2 && second_len != 0) begin
        enter(PH_DATA2);
        return;
      end
      if (hdr_bytes[5] != (frame_xor & CHK_MASK)) finish_frame(ST_CHK1);
      else if (hdr_bytes[6] != (~frame_xor & CHK_MASK)) finish_frame(ST_CHK2);
      else finish_frame(ST_OK);
    endfunction

    function void take_byte(logic [7:0] b);
      res_t       r;
      int         queued;
      logic [7:0] part_len;
      if (phase == PH_HEADER) begin
        hdr_bytes[byte_count] = b;
        byte_count++;
        if (byte_count < HDR_BYTES) return;
        if (hdr_bytes[0] != SYNC_BYTE) finish_frame(ST_BYTE1);
        else if (hdr_bytes[1] != SYNC_BYTE) finish_frame(ST_BYTE2);
        else if (hdr_bytes[3] != servo_id) finish_frame(ST_ID);
        else if (hdr_bytes[4] != (request_cmd | ACK_FLAG)) finish_frame(ST_CMD);
        else if (hdr_bytes[2] != frame_size()) finish_frame(ST_SIZE);
        else begin
          frame_xor = frame_size() ^ servo_id ^ (request_cmd | ACK_FLAG);
          move_on(1'b1);
        end
      end else if (phase == PH_DATA1 || phase == PH_DATA2) begin
        r               = '0;
        r.out_kind      = OUT_PAYLOAD;
        r.payload_byte  = b;
        r.payload_part  = (phase == PH_DATA2);
        r.payload_index = byte_count;
        r.last          = 1'b1;
        part_len  = (phase == PH_DATA2) ? second_len : first_len;
        frame_xor = frame_xor ^ b;
        if (byte_count != 8'hFF) byte_count++;
        if (byte_count >= part_len) begin
          // end of part: the payload is last only if no status follows it
          r.last = 1'b0;
          due_results.push_back(r);
          queued = due_results.size();
          move_on(1'b0);
          if (due_results.size() == queued) begin
            r.last = 1'b1;
            due_results[queued-1] = r;
          end
        end else begin
          due_results.push_back(r);
        end
      end
    endfunction

    function void take_tick();
      logic [15:0] lim;
      logic [3:0]  st;
      if (phase == PH_IDLE) return;
      if (phase == PH_DATA2) begin
        lim = long_to;
        st  = ST_D2_TIMEOUT;
      end else begin
        lim = short_to;
        st  = (phase == PH_HEADER) ? ST_HDR_TIMEOUT : ST_D1_TIMEOUT;
      end
      if (lim == 16'd0) lim = 16'd1;
      if (tick_count != 16'hFFFF) tick_count++;
      if (tick_count >= lim) finish_frame(st);
    endfunction

    function void note_item(logic [1:0] func, logic [7:0] b);
      if (func == FUNC_START) begin
        enter(PH_HEADER);
        frame_xor = '0;
      end else if (func == FUNC_BYTE) begin
        take_byte(b);
      end else begin
        take_tick();
      end
    endfunction

    task flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
      if (got_v !== want_v)
        flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got_v, want_v));
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d unexpected: kind %0d byte %0h status %0d",
                                results_seen, got.out_kind, got.payload_byte, got.status));
        return;
      end
      want = due_results.pop_front();
      compare_field("out_kind", 8'(got.out_kind), 8'(want.out_kind));
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("payload_part", 8'(got.payload_part), 8'(want.payload_part));
      compare_field("payload_index", got.payload_index, want.payload_index);
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("last", 8'(got.last), 8'(want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sac_in_if  in_ch ();
  sac_out_if out_ch ();

  ack_frame_tracker frames = new();

  int tx_gap_pct;          // chance of a sender gap before a transfer
  int rx_stall_pct;        // chance per cycle that the receiver starts a stall
  bit calm;                // no idling on either side
  bit hold_request;        // receiver to do its one long hold-off
  bit count_items = 1'b1;  // noise transfers are left out of the item count
  int frame_items;
  int quiet_cycles;

  servo_ack_frame_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender side: drive at the falling edge, see the transfer at the rising edge.
  // valid stays high between back-to-back transfers; a gap drops it first.
  // ---------------------------------------------------------------------------
  task push_item(logic [1:0] func, logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= func;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    frames.note_item(func, b);
    if (count_items) frame_items++;
  endtask

  // Stop offering, wait for every owed result, then let a trailing start or
  // tick settle inside the block before anything else happens.
  task wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frames.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    frames.write_reg(idx, data);
  endtask

  // Only called with the block drained, so the tracker may update at once.
  task write_regs(logic [7:0] id, logic [7:0] cmd, logic [7:0] len1, logic [7:0] len2,
                  logic [15:0] short_ms, logic [15:0] long_ms);
    put_reg(CFG_SERVO_ID, CFG_DATA_W'(id));
    put_reg(CFG_REQUEST_CMD, CFG_DATA_W'(cmd));
    put_reg(CFG_FIRST_LEN, CFG_DATA_W'(len1));
    put_reg(CFG_SECOND_LEN, CFG_DATA_W'(len2));
    put_reg(CFG_SHORT_TO, short_ms);
    put_reg(CFG_LONG_TO, long_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function logic [1:0] pick_tick();
    return ($urandom_range(0, 3) == 0) ? FUNC_ALT_TICK : FUNC_TICK;
  endfunction

  function logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly short parts so the run stays quick; empty parts are common
  function logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'd0;
    if (r < 9) return 8'($urandom_range(1, 6));
    return 8'($urandom_range(7, 24));
  endfunction

  // small limits so timeouts are reachable, zero and huge ones now and then
  function logic [15:0] pick_timeout();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3, 4:    return 16'($urandom_range(3, 25));
      default: return 16'($urandom);
    endcase
  endfunction

  function int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 35;
    endcase
  endfunction

  // Stray items: a start opens a frame; others are ignored or break an open frame.
  task send_noise();
    count_items = 1'b0;
    repeat ($urandom_range(1, 4)) push_item(2'($urandom), 8'($urandom));
    count_items = 1'b1;
  endtask

  // One ack frame for the current settings, with random payload, the odd tick
  // kept under the phase limit, and optionally one fault.
  task send_frame(frame_fault_t fault);
    logic [7:0] payload [$];
    logic [7:0] hdr [HDR_LEN];
    logic [7:0] size, ack, sum;
    int         len1, len2, lim_s, lim_l, lim, total, cut, spot, ticks, slot, i;
    bit         armed;
    len1  = frames.first_len;
    len2  = frames.second_len;
    lim_s = (frames.short_to == 0) ? 1 : frames.short_to;
    lim_l = (frames.long_to == 0) ? 1 : frames.long_to;
    size  = 8'(HDR_LEN + len1 + len2);
    ack   = frames.request_cmd | ACK_FLAG;
    sum   = size ^ frames.servo_id ^ ack;
    repeat (len1 + len2) begin
      payload.push_back(8'($urandom));
      sum = sum ^ payload[$];
    end
    hdr = '{SYNC_BYTE, SYNC_BYTE, size, frames.servo_id, ack,
            sum & CHK_MASK, ~sum & CHK_MASK};
    case (fault)
      FAULT_SYNC0: slot = 0;
      FAULT_SYNC1: slot = 1;
      FAULT_SIZE:  slot = 2;
      FAULT_ID:    slot = 3;
      FAULT_CMD:   slot = 4;
      FAULT_CHK1:  slot = 5;
      FAULT_CHK2:  slot = 6;
      default:     slot = -1;
    endcase
    if (slot >= 0) hdr[slot] = hdr[slot] ^ 8'($urandom_range(1, 255));
    total = HDR_LEN + len1 + len2;
    cut   = (fault == FAULT_TRUNCATE) ? $urandom_range(0, total - 1) : total;

    push_item(FUNC_START, 8'($urandom));
    lim   = lim_s;
    spot  = $urandom_range(0, HDR_LEN - 1);
    armed = (fault == FAULT_HDR_TIMEOUT);
    ticks = 0;
    for (i = 0; i < total; i++) begin
      if (i == cut) return;
      // each data part starts its own tick count
      if (i == HDR_LEN || i == HDR_LEN + len1) begin
        if (i == HDR_LEN && len1 != 0) begin
          lim   = lim_s;
          spot  = i + $urandom_range(0, len1 - 1);
          armed = (fault == FAULT_D1_TIMEOUT);
        end else begin
          lim   = lim_l;
          spot  = i + $urandom_range(0, len2 - 1);
          armed = (fault == FAULT_D2_TIMEOUT);
        end
        ticks = 0;
      end
      if (armed && i == spot && lim - ticks <= TIMEOUT_REACH) begin
        repeat (lim - ticks) push_item(pick_tick(), 8'($urandom));
        return;
      end
      if (lim > ticks + 1 && $urandom_range(0, 9) == 0) begin
        push_item(pick_tick(), 8'($urandom));
        ticks++;
      end
      push_item(FUNC_BYTE, (i < HDR_LEN) ? hdr[i] : payload[i - HDR_LEN]);
      // a bad header field ends the frame at the seventh byte
      if (i == HDR_LEN - 1 && slot >= 0 && slot <= 4) return;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: ready in random stall bursts, or one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        n = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest owed result.
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.out_kind      = out_ch.out_kind;
      got.payload_byte  = out_ch.payload_byte;
      got.payload_part  = out_ch.payload_part;
      got.payload_index = out_ch.payload_index;
      got.status        = out_ch.status;
      got.last          = out_ch.last;
      frames.check_result(got);
    end
  end

  // Watchdog: too long without a transfer on either channel means a hang.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("servo_ack_frame_checker verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    // sound ack for id 0, command 0xFF, both parts empty: checksum 0xF8
    logic [7:0]   good_hdr [HDR_LEN];
    int           phase_no, n_frames, k;
    frame_fault_t fault;

    good_hdr      = '{8'hFF, 8'hFF, 8'h07, 8'h00, 8'hFF, 8'hF8, 8'h06};
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_START;
    in_ch.rx_byte = '0;
    tx_gap_pct    = 20;
    rx_stall_pct  = 10;
    calm          = 1'b0;
    hold_request  = 1'b0;
    frame_items   = 0;
    quiet_cycles  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero timeouts (behave as one tick), empty parts
    write_regs(8'h00, 8'hFF, 8'd0, 8'd0, 16'd0, 16'd0);
    // idle: bytes and both tick codes give nothing
    push_item(FUNC_BYTE, SYNC_BYTE);
    push_item(FUNC_TICK, 8'h00);
    push_item(FUNC_ALT_TICK, 8'hAA);
    // header timeout on the first tick
    push_item(FUNC_START, 8'h55);
    push_item(FUNC_TICK, 8'hFF);
    // restart mid-header drops the partial frame; then a sound frame
    push_item(FUNC_START, 8'h00);
    push_item(FUNC_BYTE, SYNC_BYTE);
    push_item(FUNC_BYTE, SYNC_BYTE);
    push_item(FUNC_START, 8'h00);
    foreach (good_hdr[j]) push_item(FUNC_BYTE, good_hdr[j]);
    // first sync byte wrong
    push_item(FUNC_START, 8'hFF);
    repeat (HDR_LEN) push_item(FUNC_BYTE, 8'h00);
    wait_for_drain();

    // Random: one settings block per pass, drained before the next write
    frame_items = 0;
    for (phase_no = 0; frame_items < ITEM_TARGET; phase_no++) begin
      calm     = (frame_items >= ITEM_TARGET - CALM_ITEMS);
      n_frames = $urandom_range(3, 9);
      if (phase_no == 0) begin
        // everything at its top value: size wraps to 5, parts of 255 bytes
        write_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        n_frames = 1;
      end else if (phase_no == 2) begin
        // long receiver hold-off while payload keeps coming: queue fills
        write_regs(pick_byte(), pick_byte(), 8'd10, 8'd6, 16'hFFFF, pick_timeout());
        hold_request = 1'b1;
      end else begin
        write_regs(pick_byte(), pick_byte(), pick_len(), pick_len(),
                   pick_timeout(), pick_timeout());
      end
      tx_gap_pct   = pick_pct();
      rx_stall_pct = pick_pct();
      for (k = 0; k < n_frames; k++) begin
        if (phase_no == 0 || $urandom_range(0, 99) < 40) fault = FAULT_NONE;
        else fault = frame_fault_t'($urandom_range(FAULT_SYNC0, FAULT_TRUNCATE));
        send_frame(fault);
        if ($urandom_range(0, 3) == 0) send_noise();
      end
      // sender pauses here until every owed result has arrived
      wait_for_drain();
    end

    if (frames.mismatch_count == 0 && frames.due_results.size() == 0)
      $display("servo_ack_frame_checker verification clean");
    else
      $display("servo_ack_frame_checker verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sac_pkg.sv
sv/sac_in_if.sv
sv/sac_out_if.sv
sv/sac_core.sv
sv/sac_out_fifo.sv
sv/servo_ack_frame_checker.sv
tb/servo_ack_frame_checker_tb.sv
